// File: src/wse_pkg.sv
// Shared types, constants and the arithmetic helper of the wheel speed estimator.
package wse_pkg;

    localparam logic [8:0]  SPEED_MAX      = 9'd500;
    localparam int          DISTANCE_WIDTH = 32;
    localparam logic [10:0] DEG_TO_RAD_Q16 = 11'd1144;
    localparam logic [15:0] RECIP10_Q19    = 16'd52429;
    localparam logic [8:0]  MIN_LOW        = 9'd10;
    localparam logic [8:0]  MIN_HIGH       = 9'd290;

    localparam logic [1:0] REG_PULSE_SCALE  = 2'd0;
    localparam logic [1:0] REG_BODY_RADIUS  = 2'd1;
    localparam logic [1:0] REG_TARGET_SPEED = 2'd2;

    typedef struct packed {
        logic [15:0] pulse_scale;
        logic [15:0] body_radius;
        logic [8:0]  target_speed;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic mult;
        logic wheel;
        logic turn;
        logic vehicle;
        logic accum;
        logic filter;
        logic load;
    } dp_cmd_t;

    function automatic logic [8:0] slew_clamp(input logic signed [25:0] now_v,
                                              input logic [8:0] last_v);
        logic signed [26:0] last_s;
        logic signed [26:0] diff;
        logic signed [26:0] val;
        last_s = $signed({18'b0, last_v});
        diff   = $signed({now_v[25], now_v}) - last_s;
        if (diff > 27'sd100) begin
            val = last_s + 27'sd100;
        end else if (diff < -27'sd100) begin
            val = last_s - 27'sd100;
        end else begin
            val = $signed({now_v[25], now_v});
        end
        if (val < 27'sd0) begin
            return 9'd0;
        end else if (val > $signed({18'b0, SPEED_MAX})) begin
            return SPEED_MAX;
        end
        return val[8:0];
    endfunction

endpackage

// File: src/wse_regs.sv
// Configuration register file with its APB-style access port.
module wse_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output wse_pkg::cfg_t     cfg
);
    import wse_pkg::*;

    logic [15:0] pulse_scale_reg;
    logic [15:0] body_radius_reg;
    logic [8:0]  target_speed_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_scale_reg  <= 16'd256;
            body_radius_reg  <= 16'd2560;
            target_speed_reg <= 9'd200;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_PULSE_SCALE:  pulse_scale_reg  <= pwdata[15:0];
                REG_BODY_RADIUS:  body_radius_reg  <= pwdata[15:0];
                REG_TARGET_SPEED: target_speed_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PULSE_SCALE:  prdata = {16'b0, pulse_scale_reg};
            REG_BODY_RADIUS:  prdata = {16'b0, body_radius_reg};
            REG_TARGET_SPEED: prdata = {23'b0, target_speed_reg};
            default:          prdata = 32'b0;
        endcase
    end

    assign cfg = '{pulse_scale: pulse_scale_reg, body_radius: body_radius_reg,
                   target_speed: target_speed_reg};

endmodule

// File: src/wse_ctrl.sv
// Sequencer that steps the datapath through one tick and owns the stream handshakes.
module wse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wse_pkg::dp_cmd_t  cmd
);
    import wse_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MULT    = 8'b0000_0010,
        ST_WHEEL   = 8'b0000_0100,
        ST_TURN    = 8'b0000_1000,
        ST_VEHICLE = 8'b0001_0000,
        ST_ACCUM   = 8'b0010_0000,
        ST_FILTER  = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign load     = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_MULT;
            ST_MULT:    state_next = ST_WHEEL;
            ST_WHEEL:   state_next = ST_TURN;
            ST_TURN:    state_next = ST_VEHICLE;
            ST_VEHICLE: state_next = ST_ACCUM;
            ST_ACCUM:   state_next = ST_FILTER;
            ST_FILTER:  state_next = ST_DONE;
            ST_DONE:    if (load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd = '{capture: (state_reg == ST_IDLE) && s_tvalid,
                   mult:    (state_reg == ST_MULT),
                   wheel:   (state_reg == ST_WHEEL),
                   turn:    (state_reg == ST_TURN),
                   vehicle: (state_reg == ST_VEHICLE),
                   accum:   (state_reg == ST_ACCUM),
                   filter:  (state_reg == ST_FILTER),
                   load:    load};

endmodule

// File: src/wse_dp.sv
// Datapath: wheel scaling, slew limits, yaw correction, distances, filter and gain band.
module wse_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wse_pkg::dp_cmd_t                    cmd,
    input  wse_pkg::cfg_t                       cfg,
    input  logic [15:0]                         left_pulses,
    input  logic [15:0]                         right_pulses,
    input  logic                                left_direction,
    input  logic                                right_direction,
    input  logic signed [15:0]                  yaw_rate,
    input  logic                                roundabout_active,
    input  logic [1:0]                          distance_clear,
    output logic [8:0]                          left_speed,
    output logic [8:0]                          right_speed,
    output logic [8:0]                          vehicle_speed,
    output logic [wse_pkg::DISTANCE_WIDTH-1:0]  run_distance,
    output logic [wse_pkg::DISTANCE_WIDTH-1:0]  roundabout_distance,
    output logic [8:0]                          smoothed_min_speed,
    output logic [1:0]                          gain_band
);
    import wse_pkg::*;

    logic [15:0]                lp_reg, rp_reg;
    logic                       ldir_reg, rdir_reg, active_reg;
    logic signed [15:0]         yaw_reg;
    logic [1:0]                 clr_reg;
    logic [31:0]                lprod_reg, rprod_reg;
    logic signed [31:0]         yprod_reg;
    logic signed [42:0]         corr_reg;
    logic signed [21:0]         turn_reg;
    logic [28:0]                fprod_reg;

    logic [8:0]                 left_reg, right_reg, veh_reg, min_reg;
    logic [DISTANCE_WIDTH-1:0]  run_reg, rd_reg;

    logic [8:0]                 left_out_reg, right_out_reg, veh_out_reg, min_out_reg;
    logic [DISTANCE_WIDTH-1:0]  run_out_reg, rd_out_reg;
    logic [1:0]                 band_out_reg;

    logic signed [31:0]         yprod_next;
    logic signed [42:0]         corr_next;
    logic signed [25:0]         lraw, rraw;
    logic signed [45:0]         t_right, t_left, t_sel;
    logic signed [45:0]         t_shift;
    logic signed [21:0]         turn_next;
    logic [9:0]                 wheel_sum;
    logic [DISTANCE_WIDTH-1:0]  run_base, rd_base, run_next, rd_next;
    logic [12:0]                filt_sum;
    logic [9:0]                 m_raw;
    logic [8:0]                 m_clamped;
    logic [12:0]                m_x10, set_x3, set_x7;
    logic [1:0]                 band;

    assign yprod_next = $signed({1'b0, cfg.body_radius}) * yaw_reg;
    assign corr_next  = yprod_reg * $signed({1'b0, DEG_TO_RAD_Q16});

    assign lraw = ldir_reg ? $signed({2'b0, lprod_reg[31:8]})
                           : -$signed({2'b0, lprod_reg[31:8]});
    assign rraw = rdir_reg ? -$signed({2'b0, rprod_reg[31:8]})
                           : $signed({2'b0, rprod_reg[31:8]});

    assign t_right   = $signed({13'b0, right_reg, 24'b0}) - {{3{corr_reg[42]}}, corr_reg};
    assign t_left    = $signed({13'b0, left_reg, 24'b0}) + {{3{corr_reg[42]}}, corr_reg};
    assign wheel_sum = {1'b0, left_reg} + {1'b0, right_reg};

    always_comb begin
        t_sel     = t_right;
        t_shift   = '0;
        turn_next = $signed({13'b0, wheel_sum[9:1]});
        if (yaw_reg > 16'sd50 || yaw_reg < -16'sd50) begin
            t_sel   = (yaw_reg > 16'sd50) ? t_right : t_left;
            t_shift = t_sel >>> 24;
            if (t_sel[45] && (t_sel[23:0] != 24'b0)) begin
                turn_next = t_shift[21:0] + 22'sd1;
            end else begin
                turn_next = t_shift[21:0];
            end
        end
    end

    assign run_base = clr_reg[0] ? '0 : run_reg;
    assign rd_base  = clr_reg[1] ? '0 : rd_reg;
    assign run_next = run_base + DISTANCE_WIDTH'(veh_reg);
    assign rd_next  = active_reg ? rd_base + DISTANCE_WIDTH'(veh_reg) : rd_base;
    assign filt_sum = {4'b0, min_reg} + {1'b0, veh_reg, 3'b0} + {4'b0, veh_reg};

    assign m_raw     = fprod_reg[28:19];
    assign m_clamped = (m_raw < {1'b0, MIN_LOW})  ? MIN_LOW  :
                       (m_raw > {1'b0, MIN_HIGH}) ? MIN_HIGH : m_raw[8:0];

    assign m_x10  = {min_reg, 3'b0} + {3'b0, min_reg, 1'b0};
    assign set_x3 = {3'b0, cfg.target_speed, 1'b0} + {4'b0, cfg.target_speed};
    assign set_x7 = {2'b0, cfg.target_speed, 2'b0} + set_x3;

    always_comb begin
        if (m_x10 <= set_x3) begin
            band = 2'd0;
        end else if (m_x10 <= set_x7) begin
            band = 2'd1;
        end else if (min_reg <= cfg.target_speed) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lp_reg     <= left_pulses;
            rp_reg     <= right_pulses;
            ldir_reg   <= left_direction;
            rdir_reg   <= right_direction;
            yaw_reg    <= yaw_rate;
            active_reg <= roundabout_active;
            clr_reg    <= distance_clear;
        end
        if (cmd.mult) begin
            lprod_reg <= 32'(lp_reg) * 32'(cfg.pulse_scale);
            rprod_reg <= 32'(rp_reg) * 32'(cfg.pulse_scale);
            yprod_reg <= yprod_next;
        end
        if (cmd.wheel) begin
            corr_reg <= corr_next;
        end
        if (cmd.turn) begin
            turn_reg <= turn_next;
        end
        if (cmd.accum) begin
            fprod_reg <= 29'(filt_sum) * 29'(RECIP10_Q19);
        end
        if (cmd.load) begin
            left_out_reg  <= left_reg;
            right_out_reg <= right_reg;
            veh_out_reg   <= veh_reg;
            run_out_reg   <= run_reg;
            rd_out_reg    <= rd_reg;
            min_out_reg   <= min_reg;
            band_out_reg  <= band;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            right_reg <= '0;
            veh_reg   <= '0;
            run_reg   <= '0;
            rd_reg    <= '0;
            min_reg   <= '0;
        end else begin
            if (cmd.wheel) begin
                left_reg  <= slew_clamp(lraw, left_reg);
                right_reg <= slew_clamp(rraw, right_reg);
            end
            if (cmd.vehicle) begin
                veh_reg <= slew_clamp({{4{turn_reg[21]}}, turn_reg}, veh_reg);
            end
            if (cmd.accum) begin
                run_reg <= run_next;
                rd_reg  <= rd_next;
            end
            if (cmd.filter) begin
                min_reg <= m_clamped;
            end
        end
    end

    assign left_speed          = left_out_reg;
    assign right_speed         = right_out_reg;
    assign vehicle_speed       = veh_out_reg;
    assign run_distance        = run_out_reg;
    assign roundabout_distance = rd_out_reg;
    assign smoothed_min_speed  = min_out_reg;
    assign gain_band           = band_out_reg;

endmodule

// File: src/wheel_speed_estimator.sv
// Top level of the wheel speed estimator: stream ports, register port and block wiring.
//
// One input transfer carries one control tick and yields exactly one result transfer.
// A tick runs through a fixed seven-step sequence after it is accepted (wheel and yaw
// multiplies, wheel slew limit with the yaw constant multiply, turning speed, vehicle
// slew limit, distance sums with the filter multiply, filter clamp, result load), and
// no new tick is taken before the result of the last one is loaded. A finished result
// sits in its own output register; the next tick is accepted as soon as that result
// is loaded, and a stalled result only holds the sequencer in its final step.
// Registers come up as pulse_scale 256, body_radius 2560 and target_speed 200 and
// should be written only while no tick is in flight.
module wheel_speed_estimator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_pulses[15:0], right_pulses[31:16], left_direction[32], right_direction[33],
    // yaw_rate[49:34], roundabout_active[50], distance_clear[52:51], zero[55:53]
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_speed[8:0], right_speed[17:9], vehicle_speed[26:18], run_distance[58:27],
    // roundabout_distance[90:59], smoothed_min_speed[99:91], gain_band[101:100],
    // zero[103:102]
    output logic [103:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import wse_pkg::*;

    cfg_t                      cfg;
    dp_cmd_t                   cmd;
    logic [8:0]                left_speed, right_speed, vehicle_speed, smoothed_min_speed;
    logic [DISTANCE_WIDTH-1:0] run_distance, roundabout_distance;
    logic [1:0]                gain_band;

    wse_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    wse_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .cfg                 (cfg),
        .left_pulses         (s_tdata[15:0]),
        .right_pulses        (s_tdata[31:16]),
        .left_direction      (s_tdata[32]),
        .right_direction     (s_tdata[33]),
        .yaw_rate            ($signed(s_tdata[49:34])),
        .roundabout_active   (s_tdata[50]),
        .distance_clear      (s_tdata[52:51]),
        .left_speed          (left_speed),
        .right_speed         (right_speed),
        .vehicle_speed       (vehicle_speed),
        .run_distance        (run_distance),
        .roundabout_distance (roundabout_distance),
        .smoothed_min_speed  (smoothed_min_speed),
        .gain_band           (gain_band)
    );

    assign m_tdata = {2'b0, gain_band, smoothed_min_speed, roundabout_distance,
                      run_distance, vehicle_speed, right_speed, left_speed};

endmodule
